// ===== hw/rtl/slint_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package slint_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int IN_W        = 16;
  localparam int OUT_W       = 64;

  // difference, determinant, numerator, dividend, base and extended widths
  localparam int DIFW  = COORD_WIDTH + 1;
  localparam int DETW  = 2 * DIFW + 1;
  localparam int PW    = DETW + DIFW;
  localparam int DW    = PW + FRAC_BITS;
  localparam int BASEW = COORD_WIDTH + FRAC_BITS;
  localparam int EXW   = (DW > OUT_W) ? DW : OUT_W;

  localparam int QDEPTH = 4;
  localparam int QIW    = $clog2(QDEPTH);

  localparam logic [OUT_W-1:0] QCAP    = 64'h8100_0000_0000_0000;
  localparam logic [OUT_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_PARALLEL = 2'd0,
    ST_NONE     = 2'd1,
    ST_HIT      = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [DETW-1:0]    d_mag;
    logic [DW-1:0]      num_x;
    logic [DW-1:0]      num_y;
    logic               qneg_x;
    logic               qneg_y;
    logic               bneg_x;
    logic               bneg_y;
    logic [BASEW-1:0]   base_x;
    logic [BASEW-1:0]   base_y;
  } job_t;

  function automatic logic signed [DIFW-1:0] sx(input logic [IN_W-1:0] f);
    logic signed [COORD_WIDTH-1:0] c;
    c = signed'(f[COORD_WIDTH-1:0]);
    return DIFW'(c);
  endfunction

  // sign-magnitude sum to saturated two's complement
  function automatic logic [OUT_W-1:0] sat_add(input logic n1, input logic [OUT_W-1:0] m1,
                                               input logic n2, input logic [OUT_W-1:0] m2);
    logic [OUT_W-1:0] m;
    logic             n;
    if (n1 == n2) begin
      m = m1 + m2;
      n = n1;
    end else if (m1 >= m2) begin
      m = m1 - m2;
      n = n1;
    end else begin
      m = m2 - m1;
      n = n2;
    end
    if (n) begin
      return (m >= NEG_MIN) ? NEG_MIN : (~m + 1'b1);
    end
    return (m > POS_MAX) ? POS_MAX : m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/segment_line_intersection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Intersection of two 2D lines, each given by two integer endpoints.
// Input channel: in_valid/in_ready carry op (0 proper segment test, 1 infinite
// lines) and the eight signed endpoint coordinates of lines a and b.
// Result channel: out_valid/out_ready carry out_status (0 parallel, 1 no
// proper intersection, 2 found) and out_point_x/out_point_y in signed fixed
// point with FRAC_BITS fraction bits, saturated, zero unless status is 2.
// Throughput: one transfer per cycle on each side unless the receiver
// stalls. The front stage forms the three determinants and the scaled
// numerators, a 4-entry queue sits between it and the back end, and the
// back end is a restoring divider pipelined one quotient bit per stage,
// then a saturating add stage. The dividend width DW is 68 by default.
// When the receiver stalls the whole back pipeline holds; the queue then
// absorbs items until it is full, and only then in_ready falls.
// Synchronous reset clears all valid bits and the queue; results in flight
// are dropped and the block is ready again the cycle after reset.
module segment_line_intersection (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_op,
  input  wire [slint_pkg::IN_W-1:0]    in_a_from_x,
  input  wire [slint_pkg::IN_W-1:0]    in_a_from_y,
  input  wire [slint_pkg::IN_W-1:0]    in_a_to_x,
  input  wire [slint_pkg::IN_W-1:0]    in_a_to_y,
  input  wire [slint_pkg::IN_W-1:0]    in_b_from_x,
  input  wire [slint_pkg::IN_W-1:0]    in_b_from_y,
  input  wire [slint_pkg::IN_W-1:0]    in_b_to_x,
  input  wire [slint_pkg::IN_W-1:0]    in_b_to_y,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic [slint_pkg::OUT_W-1:0]  out_point_x,
  output logic [slint_pkg::OUT_W-1:0]  out_point_y
);
  import slint_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, pop_job;

  slint_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_a_from_x (in_a_from_x),
    .in_a_from_y (in_a_from_y),
    .in_a_to_x   (in_a_to_x),
    .in_a_to_y   (in_a_to_y),
    .in_b_from_x (in_b_from_x),
    .in_b_from_y (in_b_from_y),
    .in_b_to_x   (in_b_to_x),
    .in_b_to_y   (in_b_to_y),
    .push        (push),
    .push_job    (push_job),
    .full        (full)
  );

  slint_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_job  (pop_job)
  );

  slint_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop         (pop),
    .empty       (empty),
    .pop_job     (pop_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/slint_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slint_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_op,
  input  wire [slint_pkg::IN_W-1:0]  in_a_from_x,
  input  wire [slint_pkg::IN_W-1:0]  in_a_from_y,
  input  wire [slint_pkg::IN_W-1:0]  in_a_to_x,
  input  wire [slint_pkg::IN_W-1:0]  in_a_to_y,
  input  wire [slint_pkg::IN_W-1:0]  in_b_from_x,
  input  wire [slint_pkg::IN_W-1:0]  in_b_from_y,
  input  wire [slint_pkg::IN_W-1:0]  in_b_to_x,
  input  wire [slint_pkg::IN_W-1:0]  in_b_to_y,
  output logic                       push,
  output slint_pkg::job_t            push_job,
  input  wire                        full
);
  import slint_pkg::*;

  logic signed [DIFW-1:0] afx, afy, vx, vy, wx, wy, ux, uy;
  logic signed [DETW-1:0] d0_c, fa_c, fb_c;

  logic                   valid_r;
  logic                   op_r;
  logic signed [DETW-1:0] d0_r, fa_r, fb_r;
  logic signed [DIFW-1:0] vx_r, vy_r, afx_r, afy_r;

  always_comb begin
    afx  = sx(in_a_from_x);
    afy  = sx(in_a_from_y);
    vx   = sx(in_a_to_x) - afx;
    vy   = sx(in_a_to_y) - afy;
    wx   = sx(in_b_from_x) - sx(in_b_to_x);
    wy   = sx(in_b_from_y) - sx(in_b_to_y);
    ux   = sx(in_b_from_x) - afx;
    uy   = sx(in_b_from_y) - afy;
    d0_c = vx * wy - vy * wx;
    fa_c = ux * wy - uy * wx;
    fb_c = vx * uy - vy * ux;
  end

  assign push     = valid_r && !full;
  assign in_ready = !valid_r || !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      op_r  <= in_op;
      d0_r  <= d0_c;
      fa_r  <= fa_c;
      fb_r  <= fb_c;
      vx_r  <= vx;
      vy_r  <= vy;
      afx_r <= afx;
      afy_r <= afy;
    end
  end

  // classify and form the scaled numerators
  logic signed [DETW-1:0] d_n, fa_n, fb_n;
  logic [DETW-1:0]        fa_m;
  logic [DIFW-1:0]        vx_m, vy_m, fx_m, fy_m;
  logic [PW-1:0]          px, py;
  logic                   dneg, faneg;

  always_comb begin
    d_n  = d0_r;
    fa_n = fa_r;
    fb_n = fb_r;
    if (!op_r && d0_r[DETW-1]) begin
      d_n  = -d0_r;
      fa_n = -fa_r;
      fb_n = -fb_r;
    end
    dneg  = d_n[DETW-1];
    faneg = fa_n[DETW-1];
    fa_m  = faneg ? DETW'(-fa_n) : DETW'(fa_n);
    vx_m  = vx_r[DIFW-1] ? DIFW'(-vx_r) : DIFW'(vx_r);
    vy_m  = vy_r[DIFW-1] ? DIFW'(-vy_r) : DIFW'(vy_r);
    fx_m  = afx_r[DIFW-1] ? DIFW'(-afx_r) : DIFW'(afx_r);
    fy_m  = afy_r[DIFW-1] ? DIFW'(-afy_r) : DIFW'(afy_r);
    px    = PW'(fa_m) * PW'(vx_m);
    py    = PW'(fa_m) * PW'(vy_m);

    if (d0_r == '0) begin
      push_job.status = ST_PARALLEL;
    end else if (!op_r && !(fa_n > 0 && fa_n < d_n && fb_n > 0 && fb_n < d_n)) begin
      push_job.status = ST_NONE;
    end else begin
      push_job.status = ST_HIT;
    end
    push_job.d_mag  = dneg ? DETW'(-d_n) : DETW'(d_n);
    push_job.num_x  = DW'(px) << FRAC_BITS;
    push_job.num_y  = DW'(py) << FRAC_BITS;
    push_job.qneg_x = (fa_n != '0) && (vx_r != '0) && (faneg ^ vx_r[DIFW-1] ^ dneg);
    push_job.qneg_y = (fa_n != '0) && (vy_r != '0) && (faneg ^ vy_r[DIFW-1] ^ dneg);
    push_job.bneg_x = afx_r[DIFW-1];
    push_job.bneg_y = afy_r[DIFW-1];
    push_job.base_x = BASEW'(fx_m) << FRAC_BITS;
    push_job.base_y = BASEW'(fy_m) << FRAC_BITS;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/slint_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slint_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  slint_pkg::job_t  push_job,
  output logic             full,
  input  wire              pop,
  output logic             empty,
  output slint_pkg::job_t  pop_job
);
  import slint_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QIW-1:0] wr_r, rd_r;
  logic [QIW:0]   cnt_r;

  assign full    = (cnt_r == (QIW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QIW+1)'(push) - (QIW+1)'(pop && !empty);
    end
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/slint_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slint_back (
  input  wire                          clk,
  input  wire                          rst_n,
  output logic                         pop,
  input  wire                          empty,
  input  slint_pkg::job_t              pop_job,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic [slint_pkg::OUT_W-1:0]  out_point_x,
  output logic [slint_pkg::OUT_W-1:0]  out_point_y
);
  import slint_pkg::*;

  // one quotient bit per stage, both axes share the divisor
  logic              valid_r [DW+1];
  job_t              job_r   [DW+1];
  logic [DETW-1:0]   remx_r  [DW+1];
  logic [DETW-1:0]   remy_r  [DW+1];
  logic [DW-1:0]     nqx_r   [DW+1];
  logic [DW-1:0]     nqy_r   [DW+1];

  logic              out_valid_r;
  status_t           status_r;
  logic [OUT_W-1:0]  px_r, py_r;
  logic              adv;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= !empty;
    end
    if (adv) begin
      job_r[0]  <= pop_job;
      remx_r[0] <= '0;
      remy_r[0] <= '0;
      nqx_r[0]  <= pop_job.num_x;
      nqy_r[0]  <= pop_job.num_y;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DETW:0] tx, ty;
    logic          gex, gey;
    always_comb begin
      tx  = {remx_r[k], nqx_r[k][DW-1]};
      ty  = {remy_r[k], nqy_r[k][DW-1]};
      gex = tx >= {1'b0, job_r[k].d_mag};
      gey = ty >= {1'b0, job_r[k].d_mag};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (adv) begin
        valid_r[k+1] <= valid_r[k];
      end
      if (adv) begin
        job_r[k+1]  <= job_r[k];
        remx_r[k+1] <= gex ? DETW'(tx - {1'b0, job_r[k].d_mag}) : DETW'(tx);
        remy_r[k+1] <= gey ? DETW'(ty - {1'b0, job_r[k].d_mag}) : DETW'(ty);
        nqx_r[k+1]  <= {nqx_r[k][DW-2:0], gex};
        nqy_r[k+1]  <= {nqy_r[k][DW-2:0], gey};
      end
    end
  end

  logic [EXW-1:0]   qx_e, qy_e;
  logic [OUT_W-1:0] qx, qy;
  job_t             jl;

  always_comb begin
    jl   = job_r[DW];
    qx_e = EXW'(nqx_r[DW]);
    qy_e = EXW'(nqy_r[DW]);
    qx   = (qx_e > EXW'(QCAP)) ? QCAP : qx_e[OUT_W-1:0];
    qy   = (qy_e > EXW'(QCAP)) ? QCAP : qy_e[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_r[DW];
    end
    if (adv) begin
      status_r <= jl.status;
      if (jl.status == ST_HIT) begin
        px_r <= sat_add(jl.bneg_x, OUT_W'(jl.base_x), jl.qneg_x, qx);
        py_r <= sat_add(jl.bneg_y, OUT_W'(jl.base_y), jl.qneg_y, qy);
      end else begin
        px_r <= '0;
        py_r <= '0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_point_x = px_r;
  assign out_point_y = py_r;

endmodule
`default_nettype wire
